// ----- hw/rtl/nci_pkg.sv -----
// Shared types, widths and helper functions for the four-point Neville interpolator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nci_pkg;

    localparam int DATA_W    = 32;
    localparam int DIV_STEPS = 32;
    localparam int NUM_NODES = 4;
    localparam int S_FIELDS  = 9;
    localparam int S_TDATA_W = ((S_FIELDS * DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + 1 + 7) / 8) * 8;

    typedef logic signed [DATA_W-1:0] q_t;
    typedef logic signed [DATA_W:0]   diff_t;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] dmag;
        logic              neg;
        logic              ovf;
    } div_lane_t;

    typedef struct packed {
        logic fault;
        q_t   t;
        q_t   x3;
        q_t   x2;
        q_t   x1;
    } pay0_t;

    typedef struct packed {
        logic fault;
        q_t   t;
        q_t   x3;
        q_t   x2;
    } pay1_t;

    typedef struct packed {
        logic fault;
    } pay2_t;

    function automatic logic [DATA_W-1:0] mag_diff(diff_t v);
        diff_t n;
        n = -v;
        return v[DATA_W] ? n[DATA_W-1:0] : v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mag_q(q_t v);
        logic [DATA_W-1:0] n;
        n = ~v + 1'b1;
        return v[DATA_W-1] ? n : v;
    endfunction

    function automatic q_t saturate(div_lane_t l);
        logic [DATA_W-1:0] lim;
        logic [DATA_W-1:0] q;
        lim = l.neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        q   = (l.ovf || (l.lo > lim)) ? lim : l.lo;
        return q_t'(l.neg ? (~q + 1'b1) : q);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nci_div_cell.sv -----
// One restoring division cell: develops one quotient bit per lane and hands
// the partial remainder and side data to the next cell. Depends on nci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nci_div_cell
    import nci_pkg::*;
#(
    parameter int LANES = 1,
    parameter int PAY_W = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  div_lane_t             lane_in  [LANES],
    input  wire logic [PAY_W-1:0] pay_in,
    output logic                  out_valid,
    output div_lane_t             lane_out [LANES],
    output logic      [PAY_W-1:0] pay_out
);

    logic              valid_reg;
    logic [PAY_W-1:0]  pay_reg;
    div_lane_t         lane_reg  [LANES];
    div_lane_t         lane_next [LANES];
    logic [DATA_W:0]   sh   [LANES];
    logic [DATA_W:0]   diff [LANES];
    logic              ge   [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sh[i]             = {lane_in[i].rem, lane_in[i].lo[DATA_W-1]};
            diff[i]           = sh[i] - {1'b0, lane_in[i].dmag};
            ge[i]             = sh[i] >= {1'b0, lane_in[i].dmag};
            lane_next[i]      = lane_in[i];
            lane_next[i].rem  = ge[i] ? diff[i][DATA_W-1:0] : sh[i][DATA_W-1:0];
            lane_next[i].lo   = {lane_in[i].lo[DATA_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg <= pay_in;
            for (int i = 0; i < LANES; i++) begin
                lane_reg[i] <= lane_next[i];
            end
        end
    end

    assign out_valid = valid_reg;
    assign pay_out   = pay_reg;
    assign lane_out  = lane_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nci_round.sv -----
// One Neville round: node differences, products, signed numerator, a chain
// of division cells and saturation, for LANES updates in parallel.
// Depends on nci_pkg and nci_div_cell.
`timescale 1ns / 1ps
`default_nettype none

module nci_round
    import nci_pkg::*;
#(
    parameter int LANES = 1,
    parameter int PAY_W = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  q_t                    xk,
    input  q_t                    xi [LANES],
    input  q_t                    t,
    input  q_t                    fk,
    input  q_t                    fi [LANES],
    input  wire logic [PAY_W-1:0] pay_in,
    output logic                  out_valid,
    output q_t                    fo [LANES],
    output logic      [PAY_W-1:0] pay_out
);

    // difference stage
    logic             a_valid_reg;
    logic [PAY_W-1:0] a_pay_reg;
    diff_t            a_dk_reg;
    diff_t            a_di_reg  [LANES];
    diff_t            a_den_reg [LANES];
    q_t               a_fk_reg;
    q_t               a_fi_reg  [LANES];

    // product stage
    logic              b_valid_reg;
    logic [PAY_W-1:0]  b_pay_reg;
    logic [2*DATA_W-1:0] b_m1_reg [LANES];
    logic [2*DATA_W-1:0] b_m2_reg [LANES];
    logic              b_s1_reg   [LANES];
    logic              b_s2_reg   [LANES];
    logic [DATA_W-1:0] b_dmag_reg [LANES];
    logic              b_dneg_reg [LANES];

    // numerator stage
    logic                c_valid_reg;
    logic [PAY_W-1:0]    c_pay_reg;
    div_lane_t           c_lane_reg  [LANES];
    div_lane_t           c_lane_next [LANES];
    logic [2*DATA_W-1:0] num [LANES];
    logic                sn  [LANES];

    // division chain
    div_lane_t        ch   [DIV_STEPS+1][LANES];
    logic [PAY_W-1:0] chp  [DIV_STEPS+1];
    logic             chv  [DIV_STEPS+1];

    // saturation stage
    logic             s_valid_reg;
    logic [PAY_W-1:0] s_pay_reg;
    q_t               s_fo_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            s_valid_reg <= chv[DIV_STEPS];
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (b_s1_reg[i] == b_s2_reg[i]) begin
                num[i] = b_m1_reg[i] + b_m2_reg[i];
                sn[i]  = b_s1_reg[i];
            end else if (b_m1_reg[i] >= b_m2_reg[i]) begin
                num[i] = b_m1_reg[i] - b_m2_reg[i];
                sn[i]  = b_s1_reg[i];
            end else begin
                num[i] = b_m2_reg[i] - b_m1_reg[i];
                sn[i]  = b_s2_reg[i];
            end
            c_lane_next[i].rem  = num[i][2*DATA_W-1:DATA_W];
            c_lane_next[i].lo   = num[i][DATA_W-1:0];
            c_lane_next[i].dmag = b_dmag_reg[i];
            c_lane_next[i].neg  = sn[i] ^ b_dneg_reg[i];
            c_lane_next[i].ovf  = num[i][2*DATA_W-1:DATA_W] >= b_dmag_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_pay_reg <= pay_in;
            a_dk_reg  <= diff_t'(xk) - diff_t'(t);
            a_fk_reg  <= fk;
            b_pay_reg <= a_pay_reg;
            c_pay_reg <= b_pay_reg;
            s_pay_reg <= chp[DIV_STEPS];
            for (int i = 0; i < LANES; i++) begin
                a_di_reg[i]   <= diff_t'(xi[i]) - diff_t'(t);
                a_den_reg[i]  <= diff_t'(xk) - diff_t'(xi[i]);
                a_fi_reg[i]   <= fi[i];
                b_m1_reg[i]   <= (2*DATA_W)'(mag_diff(a_dk_reg)) *
                                 (2*DATA_W)'(mag_q(a_fi_reg[i]));
                b_m2_reg[i]   <= (2*DATA_W)'(mag_diff(a_di_reg[i])) *
                                 (2*DATA_W)'(mag_q(a_fk_reg));
                b_s1_reg[i]   <= a_dk_reg[DATA_W] ^ a_fi_reg[i][DATA_W-1];
                b_s2_reg[i]   <= ~(a_di_reg[i][DATA_W] ^ a_fk_reg[DATA_W-1]);
                b_dmag_reg[i] <= mag_diff(a_den_reg[i]);
                b_dneg_reg[i] <= a_den_reg[i][DATA_W];
                c_lane_reg[i] <= c_lane_next[i];
                s_fo_reg[i]   <= saturate(ch[DIV_STEPS][i]);
            end
        end
    end

    assign chv[0] = c_valid_reg;
    assign chp[0] = c_pay_reg;
    assign ch[0]  = c_lane_reg;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        nci_div_cell #(
            .LANES (LANES),
            .PAY_W (PAY_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chv[g]),
            .lane_in   (ch[g]),
            .pay_in    (chp[g]),
            .out_valid (chv[g+1]),
            .lane_out  (ch[g+1]),
            .pay_out   (chp[g+1])
        );
    end

    assign out_valid = s_valid_reg;
    assign fo        = s_fo_reg;
    assign pay_out   = s_pay_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/neville_cubic_interpolation_top.sv -----
// Top level of the four-point Neville cubic interpolator: three rounds of
// division cell chains and the output register. Depends on nci_pkg, nci_round.
//
//   channel  dir  width  contents
//   s_axis   in   288    node_0..3, sample_0..3, target_point
//   m_axis   out  40     interpolated, node_fault
//
// One item enters per cycle unless m_axis stalls; three rounds of 36 stages
// each, 32 of them division cells, lead to the output register.
// Reset clears only the valid bits of the stages.
// A stalled m_axis freezes the whole pipeline; s_tready drops with it.
`timescale 1ns / 1ps
`default_nettype none

module neville_cubic_interpolation_top
    import nci_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // node_0, node_1, node_2, node_3, sample_0..sample_3, target_point
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // interpolated, node_fault, zero fill
    output logic      [M_TDATA_W-1:0] m_tdata
);

    logic en;
    q_t   x [NUM_NODES];
    q_t   f [NUM_NODES];
    q_t   t;
    logic fault;

    pay0_t pay0_in, pay0_out;
    pay1_t pay1_in, pay1_out;
    pay2_t pay2_in, pay2_out;
    logic  v0, v1, v2;
    q_t    xi0 [3];
    q_t    fi0 [3];
    q_t    fo0 [3];
    q_t    xi1 [2];
    q_t    fi1 [2];
    q_t    fo1 [2];
    q_t    xi2 [1];
    q_t    fi2 [1];
    q_t    fo2 [1];

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < NUM_NODES; i++) begin
            x[i] = q_t'(s_tdata[i*DATA_W +: DATA_W]);
            f[i] = q_t'(s_tdata[(NUM_NODES+i)*DATA_W +: DATA_W]);
        end
        t     = q_t'(s_tdata[2*NUM_NODES*DATA_W +: DATA_W]);
        fault = (x[0] == x[1]) || (x[0] == x[2]) || (x[0] == x[3]) ||
                (x[1] == x[2]) || (x[1] == x[3]) || (x[2] == x[3]);
    end

    assign pay0_in = '{fault: fault, t: t, x3: x[3], x2: x[2], x1: x[1]};
    assign xi0     = '{x[1], x[2], x[3]};
    assign fi0     = '{f[1], f[2], f[3]};

    nci_round #(
        .LANES (3),
        .PAY_W ($bits(pay0_t))
    ) u_round0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .xk        (x[0]),
        .xi        (xi0),
        .t         (t),
        .fk        (f[0]),
        .fi        (fi0),
        .pay_in    (pay0_in),
        .out_valid (v0),
        .fo        (fo0),
        .pay_out   (pay0_out)
    );

    assign pay1_in = '{fault: pay0_out.fault, t: pay0_out.t, x3: pay0_out.x3, x2: pay0_out.x2};
    assign xi1     = '{pay0_out.x2, pay0_out.x3};
    assign fi1     = '{fo0[1], fo0[2]};

    nci_round #(
        .LANES (2),
        .PAY_W ($bits(pay1_t))
    ) u_round1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v0),
        .xk        (pay0_out.x1),
        .xi        (xi1),
        .t         (pay0_out.t),
        .fk        (fo0[0]),
        .fi        (fi1),
        .pay_in    (pay1_in),
        .out_valid (v1),
        .fo        (fo1),
        .pay_out   (pay1_out)
    );

    assign pay2_in = '{fault: pay1_out.fault};
    assign xi2     = '{pay1_out.x3};
    assign fi2     = '{fo1[1]};

    nci_round #(
        .LANES (1),
        .PAY_W ($bits(pay2_t))
    ) u_round2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1),
        .xk        (pay1_out.x2),
        .xi        (xi2),
        .t         (pay1_out.t),
        .fk        (fo1[0]),
        .fi        (fi2),
        .pay_in    (pay2_in),
        .out_valid (v2),
        .fo        (fo2),
        .pay_out   (pay2_out)
    );

    assign m_tdata_next = M_TDATA_W'({pay2_out.fault,
                                      pay2_out.fault ? {DATA_W{1'b0}} : fo2[0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
